// ----- hdl/rgbls_pkg.sv -----
// Shared types and constants for the RGB LED bit-plane scanner.
package rgbls_pkg;

    // Default strip length and fixed payload widths.
    localparam int LED_COUNT_DEFAULT = 6;
    localparam int KIND_W            = 3;
    localparam int POS_W             = 3;
    localparam int COLOR_W           = 3;
    localparam int ALL_COLORS_W      = 18;
    localparam int BYTE_W            = 8;
    localparam int LED_LINES_W       = 6;
    localparam int DWELL_W           = 8;

    // Configuration port.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [DWELL_W-1:0] RED_DWELL_RESET = 8'd1;

    // One-hot color enable codes, with an all-zero off code.
    localparam logic [COLOR_W-1:0] COLOR_LINE_OFF   = 3'b000;
    localparam logic [COLOR_W-1:0] COLOR_LINE_RED   = 3'b001;
    localparam logic [COLOR_W-1:0] COLOR_LINE_GREEN = 3'b010;
    localparam logic [COLOR_W-1:0] COLOR_LINE_BLUE  = 3'b100;

    // Item operation codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_SET       = 3'd0,
        KIND_TOGGLE    = 3'd1,
        KIND_LOAD_ALL  = 3'd2,
        KIND_SHOW_BYTE = 3'd3,
        KIND_CLEAR     = 3'd4,
        KIND_TICK      = 3'd5,
        KIND_READ      = 3'd6
    } kind_t;

    // Plane selected for the next frame tick.
    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } plane_sel_t;

    // Scan state carried between the core and the edit logic.
    typedef struct packed {
        plane_sel_t           sel;
        logic [DWELL_W-1:0]   dwell;
        logic [COLOR_W-1:0]   color_line;
    } scan_t;

endpackage

// ----- hdl/rgbls_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface rgbls_in_if;
    logic                               valid;
    logic                               ready;
    logic [rgbls_pkg::KIND_W-1:0]       kind;
    logic [rgbls_pkg::POS_W-1:0]        position;
    logic [rgbls_pkg::COLOR_W-1:0]      color;
    logic [rgbls_pkg::ALL_COLORS_W-1:0] all_colors;
    logic [rgbls_pkg::BYTE_W-1:0]       byte_value;

    modport source (output valid, kind, position, color, all_colors, byte_value,
                    input ready);
    modport sink (input valid, kind, position, color, all_colors, byte_value,
                  output ready);
endinterface

interface rgbls_out_if;
    logic                              valid;
    logic                              ready;
    logic [rgbls_pkg::COLOR_W-1:0]     color_at_position;
    logic [rgbls_pkg::LED_LINES_W-1:0] led_lines;
    logic [rgbls_pkg::COLOR_W-1:0]     color_lines;

    modport source (output valid, color_at_position, led_lines, color_lines,
                    input ready);
    modport sink (input valid, color_at_position, led_lines, color_lines,
                  output ready);
endinterface

// ----- hdl/rgbls_plane_edit.sv -----
// Combinational plane edit, frame scan step and readback for one item.
module rgbls_plane_edit #(
    parameter int LED_COUNT = rgbls_pkg::LED_COUNT_DEFAULT
) (
    input  logic [rgbls_pkg::KIND_W-1:0]       kind,
    input  logic [rgbls_pkg::POS_W-1:0]        position,
    input  logic [rgbls_pkg::COLOR_W-1:0]      color,
    input  logic [rgbls_pkg::ALL_COLORS_W-1:0] all_colors,
    input  logic [rgbls_pkg::BYTE_W-1:0]       byte_value,
    input  logic [rgbls_pkg::DWELL_W-1:0]      red_dwell_ticks,
    input  logic [LED_COUNT-1:0]               red_plane,
    input  logic [LED_COUNT-1:0]               green_plane,
    input  logic [LED_COUNT-1:0]               blue_plane,
    input  rgbls_pkg::scan_t                   scan,
    input  logic [LED_COUNT-1:0]               led_line,
    output logic [LED_COUNT-1:0]               red_next,
    output logic [LED_COUNT-1:0]               green_next,
    output logic [LED_COUNT-1:0]               blue_next,
    output rgbls_pkg::scan_t                   scan_next,
    output logic [LED_COUNT-1:0]               led_line_next,
    output logic [rgbls_pkg::COLOR_W-1:0]      color_result
);
    import rgbls_pkg::*;

    localparam int ALL_EXT_W = 3 * 8;

    kind_t                 kind_op;
    logic [LED_COUNT-1:0]  pos_mask;
    logic [COLOR_W-1:0]    cur_color;
    logic [COLOR_W-1:0]    put_color;
    logic [ALL_EXT_W-1:0]  all_ext;
    logic [DWELL_W-1:0]    dwell_inc;

    assign kind_op   = kind_t'(kind);
    assign all_ext   = ALL_EXT_W'(all_colors);
    assign dwell_inc = scan.dwell + DWELL_W'(1);

    // One-hot select of the addressed LED; an out-of-range position selects none.
    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            pos_mask[i] = (position == POS_W'(i));
        end
    end

    // Present color of the addressed LED and the color a set or toggle writes.
    assign cur_color = {|(blue_plane & pos_mask), |(green_plane & pos_mask),
                        |(red_plane & pos_mask)};

    always_comb
    begin
        if (kind_op == KIND_TOGGLE && cur_color == color)
        begin
            put_color = '0;
        end
        else
        begin
            put_color = color;
        end
    end

    // Plane update for the edit operations.
    always_comb
    begin
        red_next   = red_plane;
        green_next = green_plane;
        blue_next  = blue_plane;
        case (kind_op)
            KIND_SET, KIND_TOGGLE:
            begin
                red_next   = put_color[0] ? (red_plane | pos_mask)
                                          : (red_plane & ~pos_mask);
                green_next = put_color[1] ? (green_plane | pos_mask)
                                          : (green_plane & ~pos_mask);
                blue_next  = put_color[2] ? (blue_plane | pos_mask)
                                          : (blue_plane & ~pos_mask);
            end
            KIND_LOAD_ALL:
            begin
                // LEDs whose bits lie above the 18-bit field read zeros.
                for (int i = 0; i < LED_COUNT; i++)
                begin
                    red_next[i]   = all_ext[3*i];
                    green_next[i] = all_ext[3*i+1];
                    blue_next[i]  = all_ext[3*i+2];
                end
            end
            KIND_SHOW_BYTE:
            begin
                // Byte bit k lands on LED LED_COUNT-1-k.
                for (int i = 0; i < LED_COUNT; i++)
                begin
                    red_next[LED_COUNT-1-i] = byte_value[i];
                end
                green_next = '0;
                blue_next  = '0;
            end
            KIND_CLEAR:
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Frame tick: drive the selected plane and advance the scan.
    always_comb
    begin
        scan_next     = scan;
        led_line_next = led_line;
        if (kind_op == KIND_TICK)
        begin
            case (scan.sel)
                SEL_GREEN:
                begin
                    led_line_next        = green_plane;
                    scan_next.color_line = COLOR_LINE_GREEN;
                    scan_next.sel        = SEL_BLUE;
                end
                SEL_BLUE:
                begin
                    led_line_next        = blue_plane;
                    scan_next.color_line = COLOR_LINE_BLUE;
                    scan_next.sel        = SEL_RED;
                end
                default:
                begin
                    led_line_next        = red_plane;
                    scan_next.color_line = COLOR_LINE_RED;
                    if (dwell_inc == red_dwell_ticks)
                    begin
                        scan_next.dwell = '0;
                        scan_next.sel   = SEL_GREEN;
                    end
                    else
                    begin
                        scan_next.dwell = dwell_inc;
                    end
                end
            endcase
        end
    end

    // Readback of the addressed LED after the update.
    assign color_result = {|(blue_next & pos_mask), |(green_next & pos_mask),
                           |(red_next & pos_mask)};

endmodule

// ----- hdl/rgb_led_bitplane_scanner_core.sv -----
// Top level of the RGB LED bit-plane scanner with its APB register port.
// The result of an item is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle; a single output register decouples the two
// channels, so a new item is taken whenever that register is empty or drained.
// Reset: planes, scan state and lines clear, red is selected, red_dwell_ticks
// returns to 1, and no result is pending.
module rgb_led_bitplane_scanner_core #(
    parameter int LED_COUNT = rgbls_pkg::LED_COUNT_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rgbls_in_if.sink                         in_ch,
    rgbls_out_if.source                      out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbls_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rgbls_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rgbls_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import rgbls_pkg::*;

    logic [DWELL_W-1:0]   red_dwell_reg;
    logic [LED_COUNT-1:0] red_plane_reg;
    logic [LED_COUNT-1:0] green_plane_reg;
    logic [LED_COUNT-1:0] blue_plane_reg;
    logic [LED_COUNT-1:0] led_line_reg;
    scan_t                scan_reg;
    logic                 out_valid_reg;
    logic [COLOR_W-1:0]   color_result_reg;

    logic [LED_COUNT-1:0] red_next;
    logic [LED_COUNT-1:0] green_next;
    logic [LED_COUNT-1:0] blue_next;
    logic [LED_COUNT-1:0] led_line_next;
    scan_t                scan_next;
    logic [COLOR_W-1:0]   color_result_next;
    logic                 accept;
    logic                 cfg_write;

    // Register port: a single register, so every address decodes to it.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = APB_DATA_W'(red_dwell_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_dwell_reg <= RED_DWELL_RESET;
        end
        else if (cfg_write)
        begin
            red_dwell_reg <= pwdata[DWELL_W-1:0];
        end
    end

    // Take a new item whenever the result register is free or being drained.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    rgbls_plane_edit #(
        .LED_COUNT (LED_COUNT)
    ) u_edit (
        .kind            (in_ch.kind),
        .position        (in_ch.position),
        .color           (in_ch.color),
        .all_colors      (in_ch.all_colors),
        .byte_value      (in_ch.byte_value),
        .red_dwell_ticks (red_dwell_reg),
        .red_plane       (red_plane_reg),
        .green_plane     (green_plane_reg),
        .blue_plane      (blue_plane_reg),
        .scan            (scan_reg),
        .led_line        (led_line_reg),
        .red_next        (red_next),
        .green_next      (green_next),
        .blue_next       (blue_next),
        .scan_next       (scan_next),
        .led_line_next   (led_line_next),
        .color_result    (color_result_next)
    );

    // Planes, scan state and drive lines advance on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_plane_reg   <= '0;
            green_plane_reg <= '0;
            blue_plane_reg  <= '0;
            led_line_reg    <= '0;
            scan_reg        <= '{sel: SEL_RED, dwell: '0, color_line: COLOR_LINE_OFF};
        end
        else if (accept)
        begin
            red_plane_reg   <= red_next;
            green_plane_reg <= green_next;
            blue_plane_reg  <= blue_next;
            led_line_reg    <= led_line_next;
            scan_reg        <= scan_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; led and color lines come straight from the scan registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            color_result_reg <= color_result_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.color_at_position = color_result_reg;
    assign out_ch.led_lines         = LED_LINES_W'(led_line_reg);
    assign out_ch.color_lines       = scan_reg.color_line;

endmodule

// ----- hdl/rgbls_checker.sv -----
// Port-level checker for the scanner core and its bind to the top level.
module rgbls_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [rgbls_pkg::KIND_W-1:0]  in_kind,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rgbls_pkg::COLOR_W-1:0] color_at_position,
    input logic [rgbls_pkg::COLOR_W-1:0] color_lines
);
    import rgbls_pkg::*;

    // Every accepted item shows up as a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted item produced no result");

    // With no result pending the block must take an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while result register empty");

    // At most one color enable is active at any time.
    a_color_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(color_lines))
        else $error("color enable not one-hot");

    // A clear reads back black at the addressed LED.
    a_clear_black: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_kind == KIND_CLEAR) |=> (color_at_position == '0))
        else $error("LED not black after clear");

    // A stalled result keeps its payload.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(color_at_position)))
        else $error("stalled result changed");

endmodule

bind rgb_led_bitplane_scanner_core rgbls_checker u_rgbls_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_kind           (in_ch.kind),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .color_at_position (out_ch.color_at_position),
    .color_lines       (out_ch.color_lines)
);
